FILE: design/stdp_pkg.sv
// Shared types, constants and helpers for the spike-timing plasticity block.
`timescale 1ns / 1ps

package stdp_pkg;

  localparam int SYNAPSE_COUNT = 1024;
  localparam int ADDR_BITS     = 10;
  localparam int VALUE_BITS    = 20;
  localparam int DELTA_BITS    = 16;
  localparam int CNT_BITS      = 4;
  localparam int TICK_BITS     = 32;
  localparam int FACTOR_BITS   = 16;
  localparam int POW_BITS      = FACTOR_BITS + 1;
  localparam int ENTRY_BITS    = 3 * VALUE_BITS + TICK_BITS + 1;
  localparam int IN_DATA_BITS  = 128;
  localparam int OUT_DATA_BITS = 32;

  // 1.0 in Q1.16 and the saturation limit of the elapsed tick count.
  localparam logic [POW_BITS-1:0]  ONE_Q16   = 17'h10000;
  localparam logic [TICK_BITS-1:0] DELTA_CAP = 32'h0000_FFFF;

  // Limits of a signed Q4.16 value, in the width used for sums.
  localparam logic signed [23:0] VAL_MAX = 24'sd524287;
  localparam logic signed [23:0] VAL_MIN = -24'sd524288;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // One synapse record as held in the table.
  typedef struct packed {
    logic                 seen;
    logic [TICK_BITS-1:0] last;
    value_t               minus;
    value_t               plus;
    value_t               weight;
  } entry_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DECAY_PRE  = 3'd0,
    REG_DECAY_POST = 3'd1,
    REG_WINDOW     = 3'd2,
    REG_LATENCY    = 3'd3,
    REG_CEILING    = 3'd4,
    REG_FLOOR      = 3'd5,
    REG_PLUS_STEP  = 3'd6,
    REG_MINUS_STEP = 3'd7
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accept;
    logic capture;
    logic setup;
    logic sq;
    logic mul;
    logic trace_mul;
    logic pre_add;
    logic pre_w;
    logic post_add;
    logic post_w;
    logic wr;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic is_load;
    logic need_pow;
    logic do_pre;
    logic do_post;
    logic ebit;
    logic cnt_zero;
    logic out_free;
  } dp_status_t;

  // Clamp a widened sum back into the signed Q4.16 range.
  function automatic value_t sat_val(input logic signed [23:0] v);
    value_t r;
    if (v > VAL_MAX) begin
      r = value_t'(VAL_MAX);
    end else if (v < VAL_MIN) begin
      r = value_t'(VAL_MIN);
    end else begin
      r = value_t'(v);
    end
    return r;
  endfunction

endpackage

FILE: design/stdp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module stdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/stdp_ctrl.sv
// Sequencing state machine for the plasticity update.
`timescale 1ns / 1ps

module stdp_ctrl import stdp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [14:0] {
    S_CLEAR    = 15'h0001,
    S_IDLE     = 15'h0002,
    S_READ     = 15'h0004,
    S_SETUP    = 15'h0008,
    S_BRANCH   = 15'h0010,
    S_SQ       = 15'h0020,
    S_MUL      = 15'h0040,
    S_PRE_MUL  = 15'h0080,
    S_PRE_ADD  = 15'h0100,
    S_PRE_W    = 15'h0200,
    S_POST_MUL = 15'h0400,
    S_POST_ADD = 15'h0800,
    S_POST_W   = 15'h1000,
    S_WRITE    = 15'h2000,
    S_OUT      = 15'h4000
  } state_t;

  state_t state, state_next;

  // Where to go once the decay powers are ready.
  state_t after_pow;
  assign after_pow = status.do_pre ? S_PRE_MUL : (status.do_post ? S_POST_MUL : S_WRITE);

  assign s_tready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_next  = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_BRANCH;
      end
      S_BRANCH: begin
        if (status.is_load) state_next = S_WRITE;
        else if (status.need_pow) state_next = S_SQ;
        else if (status.do_post) state_next = S_POST_MUL;
        else state_next = S_WRITE;
      end
      S_SQ: begin
        cmd.sq = 1'b1;
        if (status.ebit) state_next = S_MUL;
        else if (status.cnt_zero) state_next = after_pow;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = status.cnt_zero ? after_pow : S_SQ;
      end
      S_PRE_MUL: begin
        cmd.trace_mul = 1'b1;
        state_next    = S_PRE_ADD;
      end
      S_PRE_ADD: begin
        cmd.pre_add = 1'b1;
        state_next  = S_PRE_W;
      end
      S_PRE_W: begin
        cmd.pre_w  = 1'b1;
        state_next = status.do_post ? S_POST_MUL : S_WRITE;
      end
      S_POST_MUL: begin
        cmd.trace_mul = 1'b1;
        state_next    = S_POST_ADD;
      end
      S_POST_ADD: begin
        cmd.post_add = 1'b1;
        state_next   = S_POST_W;
      end
      S_POST_W: begin
        cmd.post_w = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr     = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register; reset starts the table clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  // The clearing sweep runs once after reset only.
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |=> (state != S_CLEAR))
    else $error("clearing sweep re-entered");

  // A table write is always followed by the result hand-off.
  a_write_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |=> (state == S_OUT))
    else $error("write not followed by output stage");

  // An accepted request always starts with the table read.
  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_READ))
    else $error("accepted request did not read the table");
`endif

endmodule

FILE: design/stdp_dp.sv
// Datapath: configuration, synapse table, decay power lanes and weight update.
`timescale 1ns / 1ps

module stdp_dp import stdp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [VALUE_BITS-1:0]    cfg_data,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  input  logic                     s_tuser,
  input  logic                     m_tready,
  output logic                     m_tvalid,
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  output logic                     m_tuser,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status
);

  // Configuration registers.
  logic [FACTOR_BITS-1:0] dpre, dpost, win, lat;
  value_t                 ceil_w, floor_w, pstep, mstep;

  always_ff @(posedge clk) begin
    if (rst) begin
      dpre    <= 16'd65209;
      dpost   <= 16'd65209;
      win     <= 16'd1;
      lat     <= 16'd0;
      ceil_w  <= 20'sd65536;
      floor_w <= 20'sd0;
      pstep   <= 20'sd655;
      mstep   <= -20'sd688;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DECAY_PRE:  dpre    <= cfg_data[FACTOR_BITS-1:0];
        REG_DECAY_POST: dpost   <= cfg_data[FACTOR_BITS-1:0];
        REG_WINDOW:     win     <= cfg_data[FACTOR_BITS-1:0];
        REG_LATENCY:    lat     <= cfg_data[FACTOR_BITS-1:0];
        REG_CEILING:    ceil_w  <= cfg_data;
        REG_FLOOR:      floor_w <= cfg_data;
        REG_PLUS_STEP:  pstep   <= cfg_data;
        REG_MINUS_STEP: mstep   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request fields.
  logic                 is_load, pe, poe;
  logic [ADDR_BITS-1:0] idx;
  value_t               load_w;
  logic [TICK_BITS-1:0] now_t, pre_t, post_t;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_load <= ~s_tuser;
      idx     <= s_tdata[9:0];
      load_w  <= s_tdata[29:10];
      now_t   <= s_tdata[61:30];
      pe      <= s_tdata[62];
      pre_t   <= s_tdata[94:63];
      poe     <= s_tdata[95];
      post_t  <= s_tdata[127:96];
    end
  end

  // Synapse table, cleared once after reset.
  logic [ADDR_BITS-1:0] clr_addr;
  entry_t               rd_entry, wr_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  stdp_ram #(.WIDTH(ENTRY_BITS), .DEPTH(SYNAPSE_COUNT)) u_table (
    .clk   (clk),
    .we    (cmd.clear | cmd.wr),
    .waddr (cmd.clear ? clr_addr : idx),
    .wdata (cmd.clear ? '0 : wr_entry),
    .raddr (s_tdata[9:0]),
    .rdata (rd_entry)
  );

  // Working copy of the entry.
  value_t               w, p, m;
  logic [TICK_BITS-1:0] last;
  logic                 seen;

  assign wr_entry = '{seen: seen, last: last, minus: m, plus: p, weight: w};

  // Event and elapsed-time evaluation.
  logic [TICK_BITS:0]   now_x, pre_end, post_end;
  logic                 pre_win, post_win, both, evt_pre, evt_post, full, need;
  logic [TICK_BITS-1:0] base, d;
  logic [DELTA_BITS-1:0] e_sat;

  always_comb begin
    now_x    = {1'b0, now_t};
    pre_end  = {1'b0, pre_t} + (TICK_BITS + 1)'(win);
    post_end = {1'b0, post_t} + (TICK_BITS + 1)'(win);
    pre_win  = (now_t >= pre_t) && (now_x < pre_end);
    post_win = now_x < post_end;
    both     = pe && poe;
    evt_pre  = both && seen && pre_win;
    evt_post = both && post_win;
    base     = seen ? last : pre_t;
    d        = (now_t >= base) ? (now_t - base) : '0;
    e_sat    = (d > DELTA_CAP) ? DELTA_CAP[DELTA_BITS-1:0] : d[DELTA_BITS-1:0];
    full     = (d < TICK_BITS'(lat)) && !evt_pre;
    need     = evt_pre || (evt_post && !full);
  end

  // Flags and power loop control.
  logic                  do_pre, do_post, need_pow, changed;
  logic [DELTA_BITS-1:0] e;
  logic [CNT_BITS-1:0]   cnt;
  logic [POW_BITS-1:0]   rp, rm;
  logic                  ebit;

  assign ebit = e[cnt];

  // Two shared multiplier lanes: decay powers, then trace scaling.
  logic signed [20:0] opa_p, opa_m;
  logic signed [17:0] opb_p, opb_m;
  logic signed [38:0] mul_p, mul_m, prod_p, prod_m;

  always_comb begin
    if (cmd.trace_mul) begin
      opa_p = 21'(p);
      opa_m = 21'(m);
      opb_p = {1'b0, rp};
      opb_m = {1'b0, rm};
    end else begin
      opa_p = {4'b0, rp};
      opa_m = {4'b0, rm};
      opb_p = cmd.mul ? {2'b0, dpre}  : {1'b0, rp};
      opb_m = cmd.mul ? {2'b0, dpost} : {1'b0, rm};
    end
    mul_p = opa_p * opb_p;
    mul_m = opa_m * opb_m;
  end

  // Scaled traces (floor shift) and the sums built on them.
  logic signed [23:0] sh_p, sh_m, sum_p, sum_m, wsum_pre, wsum_post;
  value_t             nw_pre, nw_post;

  always_comb begin
    sh_p      = 24'(prod_p >>> 16);
    sh_m      = 24'(prod_m >>> 16);
    sum_p     = sh_p + 24'(pstep);
    sum_m     = sh_m + 24'(mstep);
    wsum_pre  = 24'(w) + 24'(m);
    wsum_post = 24'(w) + 24'(p);
    nw_pre    = sat_val(wsum_pre);
    nw_post   = sat_val(wsum_post);
  end

  // Entry and arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      w    <= rd_entry.weight;
      p    <= rd_entry.plus;
      m    <= rd_entry.minus;
      last <= rd_entry.last;
      seen <= rd_entry.seen;
    end
    if (cmd.setup) begin
      do_pre   <= evt_pre && !is_load;
      do_post  <= evt_post && !is_load;
      need_pow <= need && !is_load;
      changed  <= is_load || evt_pre || evt_post;
      e        <= e_sat;
      cnt      <= CNT_BITS'(DELTA_BITS - 1);
      rp       <= need ? ONE_Q16 : '0;
      rm       <= need ? ONE_Q16 : '0;
      if (is_load) begin
        w    <= load_w;
        p    <= '0;
        m    <= '0;
        seen <= 1'b0;
      end else if (both && !seen) begin
        last <= pre_t;
        seen <= 1'b1;
      end
    end
    if (cmd.sq) begin
      rp <= mul_p[32:16];
      rm <= mul_m[32:16];
      if (!ebit && cnt != '0) cnt <= cnt - 1'b1;
    end
    if (cmd.mul) begin
      rp <= mul_p[32:16];
      rm <= mul_m[32:16];
      if (cnt != '0) cnt <= cnt - 1'b1;
    end
    if (cmd.trace_mul) begin
      prod_p <= mul_p;
      prod_m <= mul_m;
    end
    if (cmd.pre_add) begin
      p <= sat_val(sum_p);
      m <= sat_val(sh_m);
    end
    if (cmd.pre_w) begin
      w    <= (nw_pre < floor_w) ? floor_w : nw_pre;
      last <= now_t;
    end
    if (cmd.post_add) begin
      p <= sat_val(sh_p);
      m <= sat_val(sum_m);
    end
    if (cmd.post_w) begin
      w    <= (nw_post > ceil_w) ? ceil_w : nw_post;
      last <= now_t;
    end
  end

  // Output register; holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {2'b0, w, idx};
      m_tuser <= changed;
    end
  end

  assign status = '{
    clear_done: (clr_addr == ADDR_BITS'(SYNAPSE_COUNT - 1)),
    is_load:    is_load,
    need_pow:   need_pow,
    do_pre:     do_pre,
    do_post:    do_post,
    ebit:       ebit,
    cnt_zero:   (cnt == '0),
    out_free:   (!m_tvalid || m_tready)
  };

endmodule

FILE: design/stdp_synapse_weight_update.sv
// Top level of the spike-timing plasticity weight update block.
//
// Requests arrive on the s_ stream. s_tuser selects the operation: low loads a
// synapse weight and clears its traces, high evaluates the synapse against the
// pre and post spike times in s_tdata. Each request gives exactly one result
// on the m_ stream: the synapse index and its weight after the request in
// m_tdata, and m_tuser set when weight or traces were updated.
// The configuration port writes one register per cycle while cfg_we is high.
// One request is handled at a time. A load, or an evaluate that updates
// nothing, goes from the table read through setup to the table write; an
// evaluate may first run the decay power loop: 16 squaring steps plus one
// multiply step for each set bit of the elapsed tick count, on two multiplier
// lanes, then the trace and weight update steps and a table write.
// The next request can be taken in the cycle after the result is loaded, so a
// new request is not accepted before the last one's result is loaded.
// After reset the synapse table is swept clear, all 1024 entries, during which
// no request is taken. The result sits in an output register; while the
// receiver stalls it holds, and the next request is taken once it has moved
// into that register's place.
`timescale 1ns / 1ps

module stdp_synapse_weight_update import stdp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [VALUE_BITS-1:0]    cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // synapse_index, load_weight, now_tick, pre_fired_ever, pre_tick,
  // post_fired_ever, post_tick
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // op
  input  logic                     s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // result_index, new_weight, zero fill
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  // changed
  output logic                     m_tuser
);

  dp_cmd_t    cmd;
  dp_status_t status;

  stdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  stdp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: sim/stdp_synapse_weight_update_tb.sv
// Self-checking testbench for the spike-timing plasticity weight update block.
`timescale 1ns / 1ps

module stdp_synapse_weight_update_tb;
  import stdp_pkg::*;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [2:0]               cfg_index;
  logic [VALUE_BITS-1:0]    cfg_data;
  logic                     s_tvalid;
  logic                     s_tready;
  // synapse_index, load_weight, now_tick, pre_fired_ever, pre_tick,
  // post_fired_ever, post_tick
  logic [IN_DATA_BITS-1:0]  s_tdata;
  // op
  logic                     s_tuser;
  logic                     m_tvalid;
  logic                     m_tready;
  // result_index, new_weight, zero fill
  logic [OUT_DATA_BITS-1:0] m_tdata;
  // changed
  logic                     m_tuser;

  localparam bit OP_LOAD = 1'b0;
  localparam bit OP_EVAL = 1'b1;
  localparam longint VMAX = 524287;
  localparam longint VMIN = -524288;

  typedef struct {
    bit [9:0]  idx;
    bit [19:0] weight;
    bit        changed;
  } weight_result_t;

  weight_result_t weight_results_due[$];

  // Copy of the configuration and of the synapse table.
  longint unsigned decay_pre, decay_post;
  int unsigned     window_len, latency_len;
  longint          ceiling_w, floor_w, plus_inc, minus_inc;
  longint          weight_tab [SYNAPSE_COUNT];
  longint          plus_tab   [SYNAPSE_COUNT];
  longint          minus_tab  [SYNAPSE_COUNT];
  int unsigned     last_tab   [SYNAPSE_COUNT];
  bit              seen_tab   [SYNAPSE_COUNT];
  bit              loaded_tab [SYNAPSE_COUNT];
  int unsigned     clock_tab  [SYNAPSE_COUNT];

  int  err_count;
  int  requests_sent;
  int  results_seen;
  bit  idle_on;

  stdp_synapse_weight_update DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous fixed limit on the whole run.
  initial begin
    #20ms;
    $display("** stdp_synapse_weight_update: FAILED **");
    $finish;
  end

  // Arithmetic of the block.
  function automatic longint sat_q(longint v);
    return v > VMAX ? VMAX : (v < VMIN ? VMIN : v);
  endfunction

  function automatic longint unsigned decay_power(longint unsigned f, int unsigned e);
    longint unsigned r;
    r = 65536;
    for (int b = DELTA_BITS - 1; b >= 0; b--) begin
      r = (r * r) >> 16;
      if (e[b]) r = (r * f) >> 16;
    end
    return r;
  endfunction

  function automatic longint scale_q(longint t, longint unsigned f);
    longint p;
    p = t * longint'(f);
    return p >>> 16;
  endfunction

  function automatic int unsigned ticks_between(int unsigned now, int unsigned last);
    int unsigned d;
    d = now >= last ? now - last : 0;
    return d > 65535 ? 65535 : d;
  endfunction

  // Work out the result of one accepted request and update the table copy.
  task automatic predict_update(bit op, bit [9:0] idx, bit [19:0] lw, int unsigned now,
                                bit pre_ev, int unsigned pre_t, bit post_ev,
                                int unsigned post_t);
    weight_result_t r;
    longint p, m, nw;
    longint unsigned fp, fm;
    bit post_in, prev_valid;
    int unsigned prev_last, base, d, e;
    r.changed = 1'b0;
    prev_valid = 1'b0;
    prev_last = 0;
    if (op == OP_LOAD) begin
      weight_tab[idx] = longint'(signed'(lw));
      plus_tab[idx] = 0;
      minus_tab[idx] = 0;
      seen_tab[idx] = 1'b0;
      r.changed = 1'b1;
    end else if (pre_ev && post_ev) begin
      post_in = {32'd0, now} < {32'd0, post_t} + 64'(window_len);
      if (!seen_tab[idx]) begin
        last_tab[idx] = pre_t;
        seen_tab[idx] = 1'b1;
      end else if (now >= pre_t && {32'd0, now} < {32'd0, pre_t} + 64'(window_len)) begin
        // Presynaptic event: depression.
        e = ticks_between(now, last_tab[idx]);
        p = sat_q(scale_q(plus_tab[idx], decay_power(decay_pre, e)) + plus_inc);
        m = sat_q(scale_q(minus_tab[idx], decay_power(decay_post, e)));
        nw = sat_q(weight_tab[idx] + m);
        if (nw < floor_w) nw = sat_q(floor_w);
        weight_tab[idx] = nw;
        plus_tab[idx] = p;
        minus_tab[idx] = m;
        prev_last = last_tab[idx];
        prev_valid = 1'b1;
        last_tab[idx] = now;
        r.changed = 1'b1;
      end
      if (post_in) begin
        // Postsynaptic event: potentiation.
        base = prev_valid ? prev_last : last_tab[idx];
        d = now >= base ? now - base : 0;
        if (d < latency_len && !prev_valid) begin
          fp = 0;
          fm = 0;
        end else begin
          e = ticks_between(now, base);
          fp = decay_power(decay_pre, e);
          fm = decay_power(decay_post, e);
        end
        p = sat_q(scale_q(plus_tab[idx], fp));
        m = sat_q(scale_q(minus_tab[idx], fm) + minus_inc);
        nw = sat_q(weight_tab[idx] + p);
        if (nw > ceiling_w) nw = sat_q(ceiling_w);
        weight_tab[idx] = nw;
        plus_tab[idx] = p;
        minus_tab[idx] = m;
        last_tab[idx] = now;
        r.changed = 1'b1;
      end
    end
    r.idx = idx;
    r.weight = weight_tab[idx][19:0];
    weight_results_due.push_back(r);
  endtask

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    err_count++;
  endtask

  // Send one request and predict it once accepted.
  task automatic send_request(bit op, bit [9:0] idx, bit [19:0] lw, int unsigned now,
                              bit pre_ev, int unsigned pre_t, bit post_ev,
                              int unsigned post_t);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {post_t, post_ev, pre_t, pre_ev, now, lw, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_update(op, idx, lw, now, pre_ev, pre_t, post_ev, post_t);
    if (op == OP_LOAD) begin
      loaded_tab[idx] = 1'b1;
    end
    requests_sent++;
  endtask

  task automatic load_synapse(bit [9:0] idx, bit [19:0] w);
    send_request(OP_LOAD, idx, w, $urandom, 1'($urandom_range(0, 1)), $urandom,
                 1'($urandom_range(0, 1)), $urandom);
  endtask

  task automatic eval_synapse(bit [9:0] idx, int unsigned now, bit pre_ev, int unsigned pre_t,
                              bit post_ev, int unsigned post_t);
    send_request(OP_EVAL, idx, 20'($urandom), now, pre_ev, pre_t, post_ev, post_t);
  endtask

  // Wait for the block to drain, then write one register.
  task automatic write_reg(cfg_reg_t which, bit [19:0] value);
    s_tvalid <= 1'b0;
    while (weight_results_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (which)
      REG_DECAY_PRE:  decay_pre   = 64'(value[15:0]);
      REG_DECAY_POST: decay_post  = 64'(value[15:0]);
      REG_WINDOW:     window_len  = 32'(value[15:0]);
      REG_LATENCY:    latency_len = 32'(value[15:0]);
      REG_CEILING:    ceiling_w   = longint'(signed'(value));
      REG_FLOOR:      floor_w     = longint'(signed'(value));
      REG_PLUS_STEP:  plus_inc    = longint'(signed'(value));
      REG_MINUS_STEP: minus_inc   = longint'(signed'(value));
      default: ;
    endcase
  endtask

  // Receiver side: random stalls while idling is allowed.
  initial begin
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    weight_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (weight_results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result for synapse %0d", m_tdata[9:0]));
      end else begin
        want = weight_results_due.pop_front();
        if (m_tdata[9:0] !== want.idx)
          report_mismatch($sformatf("index %0d, expected %0d", m_tdata[9:0], want.idx));
        if (m_tdata[29:10] !== want.weight)
          report_mismatch($sformatf("synapse %0d weight %h, expected %h", want.idx,
                                    m_tdata[29:10], want.weight));
        if (m_tuser !== want.changed)
          report_mismatch($sformatf("synapse %0d changed flag %b, expected %b", want.idx,
                                    m_tuser, want.changed));
      end
    end
  end

  // Random evaluate of a loaded synapse, times mostly close to its own clock.
  task automatic random_eval(bit [9:0] idx);
    int unsigned now, pre_t, post_t, span;
    int kind;
    span = window_len > 40 ? 40 : window_len;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      eval_synapse(idx, $urandom, 1'($urandom_range(0, 1)), $urandom,
                   1'($urandom_range(0, 1)), $urandom);
    end else begin
      case (kind)
        1:       now = clock_tab[idx] + $urandom_range(60000, 200000);
        2:       now = clock_tab[idx] - $urandom_range(1, 30);
        default: now = clock_tab[idx] + $urandom_range(0, span + 6);
      endcase
      pre_t  = now - $urandom_range(0, span + 3);
      post_t = now - $urandom_range(0, span + 3);
      if ($urandom_range(0, 7) == 0) pre_t = now + $urandom_range(1, 5);
      clock_tab[idx] = now;
      eval_synapse(idx, now, $urandom_range(0, 9) != 0, pre_t, $urandom_range(0, 9) != 0,
                   post_t);
    end
  endtask

  // Directed cases on the default settings and then with the latency and window registers changed.
  task automatic test_directed();
    load_synapse(10'd0, 20'h7FFFF);
    load_synapse(10'd1023, 20'h80000);
    eval_synapse(10'd0, 100, 1'b1, 100, 1'b0, 100);
    eval_synapse(10'd0, 100, 1'b0, 100, 1'b1, 100);
    eval_synapse(10'd0, 100, 1'b1, 100, 1'b1, 100);
    eval_synapse(10'd0, 101, 1'b1, 101, 1'b1, 101);
    eval_synapse(10'd0, 150, 1'b1, 150, 1'b1, 0);
    eval_synapse(10'd0, 120, 1'b1, 120, 1'b1, 120);
    eval_synapse(10'd0, 200000, 1'b1, 200000, 1'b1, 200000);
    eval_synapse(10'd1023, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    eval_synapse(10'd1023, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    eval_synapse(10'd1023, 5, 1'b1, 5, 1'b1, 5);
    write_reg(REG_LATENCY, 20'd20);
    write_reg(REG_WINDOW, 20'd4);
    load_synapse(10'd512, 20'h01000);
    eval_synapse(10'd512, 1000, 1'b1, 1000, 1'b1, 1000);
    eval_synapse(10'd512, 1002, 1'b1, 1002, 1'b0, 0);
    // Post event only, shortly after the last update: traces fully decay.
    eval_synapse(10'd512, 1010, 1'b1, 2000, 1'b1, 1009);
    eval_synapse(10'd512, 1040, 1'b1, 2000, 1'b1, 1038);
    eval_synapse(10'd512, 1041, 1'b1, 1041, 1'b1, 1041);
    for (int i = 0; i < 4; i++) begin
      clock_tab[i == 0 ? 0 : (i == 1 ? 1023 : 512)] = 2000;
    end
  endtask

  // Write every register to a new value, extremes included at times.
  task automatic test_config_setting(int flavour);
    bit [19:0] v;
    case (flavour)
      0: begin
        write_reg(REG_DECAY_PRE, 20'h0FFFF);  write_reg(REG_DECAY_POST, 20'h00000);
        write_reg(REG_WINDOW, 20'h0FFFF);     write_reg(REG_LATENCY, 20'h0FFFF);
        write_reg(REG_CEILING, 20'h7FFFF);    write_reg(REG_FLOOR, 20'h80000);
        write_reg(REG_PLUS_STEP, 20'h7FFFF);  write_reg(REG_MINUS_STEP, 20'h80000);
      end
      1: begin
        write_reg(REG_DECAY_PRE, 20'h00000);  write_reg(REG_DECAY_POST, 20'h0FFFF);
        write_reg(REG_WINDOW, 20'h00001);     write_reg(REG_LATENCY, 20'h00000);
        write_reg(REG_CEILING, 20'h80000);    write_reg(REG_FLOOR, 20'h7FFFF);
        write_reg(REG_PLUS_STEP, 20'h80000);  write_reg(REG_MINUS_STEP, 20'h7FFFF);
      end
      default: begin
        write_reg(REG_DECAY_PRE, 20'($urandom_range(0, 2) == 0 ? $urandom_range(0, 65535)
                                                                 : $urandom_range(60000, 65535)));
        write_reg(REG_DECAY_POST, 20'($urandom_range(0, 2) == 0 ? $urandom_range(0, 65535)
                                                                  : $urandom_range(60000, 65535)));
        write_reg(REG_WINDOW, 20'($urandom_range(0, 5) == 0 ? $urandom_range(1, 65535)
                                                              : $urandom_range(1, 30)));
        write_reg(REG_LATENCY, 20'($urandom_range(0, 5) == 0 ? $urandom_range(0, 65535)
                                                               : $urandom_range(0, 40)));
        v = 20'($urandom);
        write_reg(REG_CEILING, $urandom_range(0, 1) ? v : 20'($urandom_range(0, 200000)));
        v = 20'($urandom);
        write_reg(REG_FLOOR, $urandom_range(0, 1) ? v : 20'(-$urandom_range(0, 200000)));
        v = 20'($urandom);
        write_reg(REG_PLUS_STEP, $urandom_range(0, 2) == 0 ? v : 20'($urandom_range(0, 40000)));
        v = 20'($urandom);
        write_reg(REG_MINUS_STEP, $urandom_range(0, 2) == 0 ? v
                                                              : 20'(-$urandom_range(0, 40000)));
      end
    endcase
  endtask

  // One random phase over a fresh pool of synapses.
  task automatic test_random_phase(int count);
    bit [9:0] pool [12];
    bit [9:0] idx;
    for (int i = 0; i < 12; i++) begin
      pool[i] = 10'($urandom_range(0, SYNAPSE_COUNT - 1));
      clock_tab[pool[i]] = $urandom;
      load_synapse(pool[i], $urandom_range(0, 3) == 0 ? 20'($urandom)
                                                        : 20'($urandom_range(0, 70000)));
    end
    for (int i = 0; i < count; i++) begin
      idx = pool[$urandom_range(0, 11)];
      if ($urandom_range(0, 24) == 0 || !loaded_tab[idx]) begin
        load_synapse(idx, 20'($urandom));
      end else begin
        random_eval(idx);
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_DECAY_PRE;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_LOAD;
    decay_pre   = 65209;
    decay_post  = 65209;
    window_len  = 1;
    latency_len = 0;
    ceiling_w   = 65536;
    floor_w     = 0;
    plus_inc    = 655;
    minus_inc   = -688;
    err_count = 0;
    requests_sent = 0;
    results_seen = 0;
    idle_on = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    for (int phase = 0; phase < 8; phase++) begin
      test_config_setting(phase);
      if (phase == 6) idle_on = 1'b0;
      test_random_phase(phase < 2 ? 60 : 130);
    end

    s_tvalid <= 1'b0;
    while (weight_results_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d load and evaluate requests over eight register settings,", requests_sent);
    $display("checked %0d results, %0d mismatches.", results_seen, err_count);
    if (err_count == 0) begin
      $display("** stdp_synapse_weight_update: PASSED **");
    end else begin
      $display("** stdp_synapse_weight_update: FAILED **");
    end
    $finish;
  end

endmodule

FILE: stdp_synapse_weight_update.f
design/stdp_pkg.sv
design/stdp_ram.sv
design/stdp_ctrl.sv
design/stdp_dp.sv
design/stdp_synapse_weight_update.sv
sim/stdp_synapse_weight_update_tb.sv
